[rtl/dtpg_pkg.sv]
// types, constants and helpers shared by the test pattern generator
package dtpg_pkg;

	localparam int COORD_W = 9;
	localparam int DELTA_W = 11;
	localparam int RAD_W = 22;
	localparam int ROOT_W = 11;
	localparam int REM_W = 14;
	localparam int COLOR_W = 16;
	localparam int INDEX_W = 1;
	localparam int SQRT_STEPS = RAD_W / 2;

	localparam logic [INDEX_W-1:0] REG_PATTERN_MODE = 1'd0;
	localparam logic [INDEX_W-1:0] REG_FILL_COLOR = 1'd1;

	localparam logic [9:0] RIM_LIMIT = 10'd178;
	localparam logic [9:0] WHITE_LIMIT = 10'd174;
	localparam logic [9:0] BAND_W = 10'd20;
	localparam logic [9:0] DOT_LIMIT = 10'd4;
	localparam logic [7:0] GREY_MAX = 8'd255;

	localparam logic [COLOR_W-1:0] C_WHITE = 16'hFFFF;
	localparam logic [COLOR_W-1:0] C_YELLOW = 16'hFFE0;
	localparam logic [COLOR_W-1:0] C_CYAN = 16'h07FF;
	localparam logic [COLOR_W-1:0] C_GREEN = 16'h07E0;
	localparam logic [COLOR_W-1:0] C_MAGENTA = 16'hF81F;
	localparam logic [COLOR_W-1:0] C_RED = 16'hF800;
	localparam logic [COLOR_W-1:0] C_BLUE = 16'h001F;
	localparam logic [COLOR_W-1:0] C_BLACK = 16'h0000;
	localparam logic [COLOR_W-1:0] C_BAND = 16'h02D9;

	typedef enum logic [1:0] {
		MODE_SOLID = 2'd0,
		MODE_BARS = 2'd1,
		MODE_GREY = 2'd2,
		MODE_RINGS = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [COLOR_W-1:0] fill;
		logic [2:0] bar;
		logic [7:0] grey;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0] rem;
	} sqrt_t;

	typedef struct packed {
		logic valid;
		side_t side;
		sqrt_t sq;
	} stage_t;

	function automatic logic [COLOR_W-1:0] bar_color(input logic [2:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			3'd0: c = C_WHITE;
			3'd1: c = C_YELLOW;
			3'd2: c = C_CYAN;
			3'd3: c = C_GREEN;
			3'd4: c = C_MAGENTA;
			3'd5: c = C_RED;
			3'd6: c = C_BLUE;
			default: c = C_BLACK;
		endcase
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] grey_color(input logic [7:0] v);
		return {v[7:3], v[7:2], v[7:3]};
	endfunction

	function automatic logic [COLOR_W-1:0] byte_swap(input logic [COLOR_W-1:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic band_odd(input logic [9:0] d);
		return (d >= BAND_W && d < 10'(2 * BAND_W))
			|| (d >= 10'(3 * BAND_W) && d < 10'(4 * BAND_W))
			|| (d >= 10'(5 * BAND_W) && d < 10'(6 * BAND_W))
			|| (d >= 10'(7 * BAND_W) && d < 10'(8 * BAND_W));
	endfunction

endpackage

[rtl/dtpg_sqrt_stage.sv]
// one pipeline stage of the digit-by-digit integer square root
module dtpg_sqrt_stage #(
	parameter int TOP_STEP = 10,
	parameter int NUM_STEPS = 4
) (
	input logic clk,
	input logic arst_n,
	input dtpg_pkg::stage_t in_st,
	output dtpg_pkg::stage_t out_st
);
	import dtpg_pkg::*;

	sqrt_t next_sq;
	logic valid_q;
	side_t side_q;
	sqrt_t sq_q;

	always_comb begin
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		logic [ROOT_W-1:0] q;
		r = in_st.sq.rem;
		q = in_st.sq.root;
		for (int j = 0; j < NUM_STEPS; j++) begin
			r = {r[REM_W-3:0], in_st.sq.rad[2 * (TOP_STEP - j) +: 2]};
			t = REM_W'({q, 2'b01});
			if (r >= t) begin
				r = r - t;
				q = {q[ROOT_W-2:0], 1'b1};
			end else begin
				q = {q[ROOT_W-2:0], 1'b0};
			end
		end
		next_sq.rad = in_st.sq.rad;
		next_sq.root = q;
		next_sq.rem = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_st.valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= in_st.side;
		sq_q <= next_sq;
	end

	assign out_st = {valid_q, side_q, sq_q};

endmodule

[rtl/display_test_pattern_generator_top.sv]
// top level of the display test pattern generator
//
// Usage: drive col and row with start high; a coordinate is taken at every
// rising edge with start high and busy low. busy is always low, so one pixel
// can be taken every clock cycle.
// Each transfer yields one pixel_word, RGB565 with its bytes swapped, shown
// for exactly one cycle with done high, once the coordinate has passed the
// stage 1 and 2 registers, the three square root stages and the output register.
// Results leave in the order the coordinates came in.
// The pipeline follows the ring distance path: coordinate offsets, squares,
// three stages of the square root (four, four and three root digits) and the
// colour select with output register. Throughput is one pixel per cycle.
// pattern_mode and fill_color are written through wr_en/wr_index/wr_data,
// taking effect for coordinates taken after the write.
// Reset clears both registers (solid black) and drops all items in flight.
// The receiver has no way to stall the output; it must take every strobe.
module display_test_pattern_generator_top #(
	parameter int WIDTH = 360,
	parameter int HEIGHT = 360
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [dtpg_pkg::COORD_W-1:0] col,
	input logic [dtpg_pkg::COORD_W-1:0] row,
	input logic wr_en,
	input logic [dtpg_pkg::INDEX_W-1:0] wr_index,
	input logic [dtpg_pkg::COLOR_W-1:0] wr_data,
	output logic done,
	output logic [dtpg_pkg::COLOR_W-1:0] pixel_word
);
	import dtpg_pkg::*;

	localparam int GREY_SHIFT = 27;
	localparam int GREY_NUM_W = 17;
	localparam int GREY_MUL_W = 24;
	localparam int GREY_PROD_W = GREY_NUM_W + GREY_MUL_W;
	localparam int GREY_Q_W = GREY_PROD_W - GREY_SHIFT;
	localparam logic [GREY_MUL_W-1:0] GREY_MUL =
		GREY_MUL_W'(((64'd1 << GREY_SHIFT) + 64'(HEIGHT) - 64'd2) / 64'(HEIGHT - 1));
	localparam logic [11:0] WIDTH_X = 12'(WIDTH);
	localparam logic [11:0] HEIGHT_X = 12'(HEIGHT);

	mode_t mode_q;
	logic [COLOR_W-1:0] fill_q;

	logic [11:0] dx;
	logic [11:0] dy;
	logic [2:0] bar_idx;

	logic valid_s1;
	side_t side_s1;
	logic [DELTA_W-1:0] adx_s1;
	logic [DELTA_W-1:0] ady_s1;
	logic [GREY_NUM_W-1:0] grey_num_s1;

	logic valid_s2;
	side_t side_s2;
	logic [RAD_W-1:0] rad_s2;
	logic [GREY_PROD_W-1:0] grey_prod_s2;

	logic [GREY_Q_W-1:0] grey_q;
	stage_t st2;
	stage_t st3;
	stage_t st4;
	stage_t st5;

	logic [9:0] ring_d;
	logic [COLOR_W-1:0] ring_c;
	logic [COLOR_W-1:0] color;
	logic done_s6;
	logic [COLOR_W-1:0] pixel_s6;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SOLID;
			fill_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PATTERN_MODE: mode_q <= mode_t'(wr_data[1:0]);
				REG_FILL_COLOR: fill_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1: offsets from centre, bar index, grey numerator
	always_comb begin
		dx = {2'b00, col, 1'b0} - WIDTH_X;
		dy = {2'b00, row, 1'b0} - HEIGHT_X;
		bar_idx = 3'd0;
		for (int k = 1; k < 8; k++) begin
			if (14'({col, 3'b000}) >= 14'(k * WIDTH)) begin
				bar_idx = 3'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.mode <= mode_q;
		side_s1.fill <= fill_q;
		side_s1.bar <= bar_idx;
		side_s1.grey <= '0;
		adx_s1 <= dx[11] ? DELTA_W'(-dx) : dx[DELTA_W-1:0];
		ady_s1 <= dy[11] ? DELTA_W'(-dy) : dy[DELTA_W-1:0];
		grey_num_s1 <= GREY_NUM_W'({row, 8'd0}) - GREY_NUM_W'(row);
	end

	// stage 2: squared distance, grey quotient by reciprocal
	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		rad_s2 <= RAD_W'(adx_s1) * RAD_W'(adx_s1) + RAD_W'(ady_s1) * RAD_W'(ady_s1);
		grey_prod_s2 <= GREY_PROD_W'(grey_num_s1) * GREY_PROD_W'(GREY_MUL);
	end

	always_comb begin
		grey_q = grey_prod_s2[GREY_PROD_W-1:GREY_SHIFT];
		st2.valid = valid_s2;
		st2.side = side_s2;
		st2.side.grey = (grey_q > GREY_Q_W'(GREY_MAX)) ? GREY_MAX : grey_q[7:0];
		st2.sq.rad = rad_s2;
		st2.sq.root = '0;
		st2.sq.rem = '0;
	end

	// stages 3 to 5: square root, high digits first
	dtpg_sqrt_stage #(.TOP_STEP(SQRT_STEPS - 1), .NUM_STEPS(4)) u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .in_st(st2), .out_st(st3)
	);
	dtpg_sqrt_stage #(.TOP_STEP(SQRT_STEPS - 5), .NUM_STEPS(4)) u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .in_st(st3), .out_st(st4)
	);
	dtpg_sqrt_stage #(.TOP_STEP(SQRT_STEPS - 9), .NUM_STEPS(SQRT_STEPS - 8)) u_sqrt_c (
		.clk(clk), .arst_n(arst_n), .in_st(st4), .out_st(st5)
	);

	// stage 6: colour select and byte swap
	always_comb begin
		ring_d = st5.sq.root[ROOT_W-1:1];
		if (ring_d < DOT_LIMIT) begin
			ring_c = C_YELLOW;
		end else if (ring_d > RIM_LIMIT) begin
			ring_c = C_RED;
		end else if (ring_d > WHITE_LIMIT) begin
			ring_c = C_WHITE;
		end else if (band_odd(ring_d)) begin
			ring_c = C_BAND;
		end else begin
			ring_c = C_BLACK;
		end
		case (st5.side.mode)
			MODE_SOLID: color = st5.side.fill;
			MODE_BARS: color = bar_color(st5.side.bar);
			MODE_GREY: color = grey_color(st5.side.grey);
			default: color = ring_c;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= st5.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_s6 <= byte_swap(color);
	end

	assign done = done_s6;
	assign pixel_word = pixel_s6;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result strobe without a transfer six cycles earlier");

	a_root_not_high: assert property (@(posedge clk) disable iff (!arst_n)
		st5.valid |-> (24'(st5.sq.root) * 24'(st5.sq.root)) <= 24'(st5.sq.rad))
		else $error("square root too large");

	a_root_not_low: assert property (@(posedge clk) disable iff (!arst_n)
		st5.valid |-> ((24'(st5.sq.root) + 24'd1) * (24'(st5.sq.root) + 24'd1))
			> 24'(st5.sq.rad))
		else $error("square root too small");

endmodule
